// File: rtl/core/page_framebuffer_glyph_writer_top_defines.svh
// Assertion macros shared by the glyph writer top level.
`ifndef PAGE_FRAMEBUFFER_GLYPH_WRITER_TOP_DEFINES_SVH
`define PAGE_FRAMEBUFFER_GLYPH_WRITER_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PFGW_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pfgw: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define PFGW_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pfgw: next-cycle check failed");

`endif

// File: rtl/core/pfgw_pkg.sv
package pfgw_pkg;

  localparam int DISPLAY_WIDTH  = 128;
  localparam int DISPLAY_HEIGHT = 64;
  localparam int MAX_GLYPH_BITS = 32;

  localparam int CMD_W  = 3;
  localparam int X_W    = 7;
  localparam int Y_W    = 6;
  localparam int BITS_W = 32;
  localparam int FMT_W  = 2;
  localparam int RW_W   = 6;
  localparam int IDX_W  = 10;
  localparam int BYTE_W = 8;

  localparam int PAGE_COUNT  = (DISPLAY_HEIGHT + 7) / 8;
  localparam int STORE_BYTES = DISPLAY_WIDTH * PAGE_COUNT;
  localparam int ADDR_W      = $clog2(STORE_BYTES);
  localparam int CNT_W       = $clog2(MAX_GLYPH_BITS + 1);
  localparam int PIX_IX_W    = $clog2(BITS_W);
  localparam int QUEUE_DEPTH = 2;

  localparam logic [CMD_W-1:0] CMD_CLEAR = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PIXEL = 3'd1;
  localparam logic [CMD_W-1:0] CMD_GLYPH = 3'd2;
  localparam logic [CMD_W-1:0] CMD_READ  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_FLUSH = 3'd4;

  localparam logic [FMT_W-1:0] FMT_8  = 2'd0;
  localparam logic [FMT_W-1:0] FMT_16 = 2'd1;
  localparam logic [FMT_W-1:0] FMT_24 = 2'd2;
  localparam logic [FMT_W-1:0] FMT_32 = 2'd3;

  localparam int OP_W = 3;
  localparam logic [OP_W-1:0] OP_NOP   = 3'd0;
  localparam logic [OP_W-1:0] OP_CLEAR = 3'd1;
  localparam logic [OP_W-1:0] OP_WRITE = 3'd2;
  localparam logic [OP_W-1:0] OP_READ  = 3'd3;
  localparam logic [OP_W-1:0] OP_FLUSH = 3'd4;

  typedef struct packed {
    logic [OP_W-1:0]   kind;
    logic              set_dirty;
    logic [ADDR_W-1:0] addr;
    logic [BYTE_W-1:0] mask;
    logic [BITS_W-1:0] pix;
    logic [CNT_W-1:0]  count;
  } op_t;

  typedef struct packed {
    logic busy;
    logic pop;
  } back_status_t;

endpackage

// File: rtl/core/pfgw_ram.sv
module pfgw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/core/pfgw_front.sv
module pfgw_front (
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [pfgw_pkg::CMD_W-1:0]  command,
  input  logic [pfgw_pkg::X_W-1:0]    pos_x,
  input  logic [pfgw_pkg::Y_W-1:0]    pos_y,
  input  logic                        pixel_value,
  input  logic [pfgw_pkg::BITS_W-1:0] row_bits,
  input  logic [pfgw_pkg::FMT_W-1:0]  row_format,
  input  logic [pfgw_pkg::RW_W-1:0]   row_width,
  input  logic [pfgw_pkg::IDX_W-1:0]  read_index,
  input  logic                        q_ready,
  output logic                        push,
  output pfgw_pkg::op_t               op
);
  import pfgw_pkg::*;

  localparam int ROOM_W = $clog2(DISPLAY_WIDTH + 1);
  localparam int SH_W   = $clog2(BITS_W) + 1;

  logic [CNT_W-1:0]  w_sat;
  logic [CNT_W-1:0]  span;
  logic [ROOM_W-1:0] room;
  logic [SH_W-1:0]   sh16;
  logic [BITS_W-1:0] aligned;
  logic [BITS_W-1:0] rev;
  logic              on_disp;
  logic [ADDR_W-1:0] base;

  assign in_ready = q_ready;
  assign push     = in_valid && q_ready;

  assign on_disp = (pos_x < DISPLAY_WIDTH) && (pos_y < DISPLAY_HEIGHT);
  assign w_sat   = (row_width > MAX_GLYPH_BITS) ? CNT_W'(MAX_GLYPH_BITS) : CNT_W'(row_width);
  assign room    = ROOM_W'(DISPLAY_WIDTH) - ROOM_W'(pos_x);
  assign span    = (32'(w_sat) <= 32'(room)) ? w_sat : CNT_W'(room);
  assign sh16    = SH_W'(BITS_W) - SH_W'(w_sat);
  assign base    = ADDR_W'(pos_x) + ADDR_W'(ADDR_W'(pos_y >> 3) * ADDR_W'(DISPLAY_WIDTH));

  // The first glyph pixel is moved to the top bit, then the word is reversed.
  always_comb begin
    unique case (row_format)
      FMT_8:   aligned = BITS_W'(row_bits[7:0]) << (BITS_W - 8);
      FMT_16:  aligned = BITS_W'(row_bits[15:0]) << sh16;
      FMT_24:  aligned = BITS_W'(row_bits[23:0]) << (BITS_W - 24);
      FMT_32:  aligned = row_bits;
      default: aligned = row_bits;
    endcase
    for (int k = 0; k < BITS_W; k++) begin
      rev[k] = aligned[BITS_W-1-k];
    end
  end

  always_comb begin
    op      = '0;
    op.kind = OP_NOP;
    op.addr = base;
    op.mask = BYTE_W'(1) << pos_y[2:0];
    unique case (command)
      CMD_CLEAR: begin
        op.kind      = OP_CLEAR;
        op.set_dirty = 1'b1;
      end
      CMD_PIXEL: begin
        op.kind      = OP_WRITE;
        op.set_dirty = 1'b1;
        op.pix       = BITS_W'(pixel_value);
        op.count     = on_disp ? CNT_W'(1) : '0;
      end
      CMD_GLYPH: begin
        op.kind      = OP_WRITE;
        op.set_dirty = (w_sat != '0);
        op.pix       = rev;
        op.count     = on_disp ? span : '0;
      end
      CMD_READ: begin
        if (read_index < STORE_BYTES) begin
          op.kind = OP_READ;
          op.addr = ADDR_W'(read_index);
        end
      end
      CMD_FLUSH: begin
        op.kind = OP_FLUSH;
      end
      default: begin
        op.kind = OP_NOP;
      end
    endcase
  end

endmodule

// File: rtl/core/pfgw_queue.sv
module pfgw_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  pfgw_pkg::op_t push_op,
  output logic          ready,
  output logic          valid,
  input  logic          pop,
  output pfgw_pkg::op_t head
);
  import pfgw_pkg::*;

  localparam int QP_W = $clog2(QUEUE_DEPTH);
  localparam int QC_W = $clog2(QUEUE_DEPTH + 1);

  op_t             slots [QUEUE_DEPTH];
  logic [QP_W-1:0] wr_ptr;
  logic [QP_W-1:0] rd_ptr;
  logic [QC_W-1:0] count;

  assign ready = !rst && (count != QC_W'(QUEUE_DEPTH));
  assign valid = (count != '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QP_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QP_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: rtl/core/pfgw_back.sv
module pfgw_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        q_valid,
  input  pfgw_pkg::op_t               q_op,
  output pfgw_pkg::back_status_t      status,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [pfgw_pkg::BYTE_W-1:0] read_byte,
  output logic                        was_dirty
);
  import pfgw_pkg::*;

  localparam logic [1:0] ST_SWEEP = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_WRITE = 2'd2;
  localparam logic [1:0] ST_READ  = 2'd3;

  logic [1:0]        state;
  op_t               cur;
  logic [ADDR_W-1:0] sweep_addr;
  logic              sweep_reply;
  logic [CNT_W-1:0]  rd_cnt;
  logic [CNT_W-1:0]  wr_cnt;
  logic              pend;
  logic              dirty;
  logic              res_dirty;

  logic              pop;
  logic              rd_issue;
  logic              wr_on;
  logic              wr_last;
  logic              sweep_last;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [BYTE_W-1:0] ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [BYTE_W-1:0] ram_rdata;

  pfgw_ram #(
    .WIDTH(BYTE_W),
    .DEPTH(STORE_BYTES)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign pop         = (state == ST_IDLE) && q_valid && !out_valid;
  assign status.pop  = pop;
  assign status.busy = (state != ST_IDLE);

  assign rd_issue   = (state == ST_WRITE) && (rd_cnt < cur.count);
  assign wr_on      = cur.pix[wr_cnt[PIX_IX_W-1:0]];
  assign wr_last    = pend && (wr_cnt == cur.count - CNT_W'(1));
  assign sweep_last = (sweep_addr == ADDR_W'(STORE_BYTES - 1));
  assign ram_raddr  = (state == ST_WRITE) ? cur.addr + ADDR_W'(rd_cnt) : q_op.addr;

  // Sweep writes zeros; a write merges the byte read in the previous cycle and writes it back.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = sweep_addr;
    ram_wdata = '0;
    if (state == ST_SWEEP) begin
      ram_we = 1'b1;
    end else if ((state == ST_WRITE) && pend) begin
      ram_we    = 1'b1;
      ram_waddr = cur.addr + ADDR_W'(wr_cnt);
      ram_wdata = wr_on ? (ram_rdata | cur.mask) : (ram_rdata & ~cur.mask);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_SWEEP;
      sweep_addr  <= '0;
      sweep_reply <= 1'b0;
      rd_cnt      <= '0;
      wr_cnt      <= '0;
      pend        <= 1'b0;
      dirty       <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_SWEEP: begin
          sweep_addr <= sweep_addr + 1'b1;
          if (sweep_last) begin
            state <= ST_IDLE;
            if (sweep_reply) begin
              out_valid <= 1'b1;
              read_byte <= '0;
              was_dirty <= res_dirty;
            end
          end
        end
        ST_IDLE: begin
          if (pop) begin
            cur       <= q_op;
            res_dirty <= dirty;
            rd_cnt    <= '0;
            wr_cnt    <= '0;
            pend      <= 1'b0;
            unique case (q_op.kind)
              OP_CLEAR: begin
                dirty       <= 1'b1;
                sweep_addr  <= '0;
                sweep_reply <= 1'b1;
                state       <= ST_SWEEP;
              end
              OP_WRITE: begin
                if (q_op.set_dirty) begin
                  dirty <= 1'b1;
                end
                if (q_op.count == '0) begin
                  out_valid <= 1'b1;
                  read_byte <= '0;
                  was_dirty <= dirty;
                end else begin
                  state <= ST_WRITE;
                end
              end
              OP_READ: begin
                state <= ST_READ;
              end
              OP_FLUSH: begin
                dirty     <= 1'b0;
                out_valid <= 1'b1;
                read_byte <= '0;
                was_dirty <= dirty;
              end
              default: begin
                out_valid <= 1'b1;
                read_byte <= '0;
                was_dirty <= dirty;
              end
            endcase
          end
        end
        ST_WRITE: begin
          if (rd_issue) begin
            rd_cnt <= rd_cnt + 1'b1;
          end
          pend <= rd_issue;
          if (pend) begin
            wr_cnt <= wr_cnt + 1'b1;
          end
          if (wr_last) begin
            state     <= ST_IDLE;
            out_valid <= 1'b1;
            read_byte <= '0;
            was_dirty <= res_dirty;
          end
        end
        ST_READ: begin
          state     <= ST_IDLE;
          out_valid <= 1'b1;
          read_byte <= ram_rdata;
          was_dirty <= res_dirty;
        end
      endcase
    end
  end

endmodule

// File: rtl/core/page_framebuffer_glyph_writer_top.sv
// Channel   Handshake             Payload
// input     in_valid / in_ready   command, pos_x, pos_y, pixel_value, row_bits,
//                                 row_format, row_width, read_index
// output    out_valid / out_ready read_byte, was_dirty
//
// Items are decoded on entry and held in a two-entry command queue.
// The executor handles one transaction at a time: flush, no-op and an empty
// glyph row finish straight from idle, read byte passes through a read state,
// pixel write and glyph row read each byte and write it back merged, and clear
// zeroes one byte per cycle through the single write port of the store.
// The next item starts only after the previous result is taken.
// After reset the executor zeroes the store while items queue.
// A stalled output holds its result and the queue keeps accepting until full.
`include "page_framebuffer_glyph_writer_top_defines.svh"

module page_framebuffer_glyph_writer_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [pfgw_pkg::CMD_W-1:0]  command,
  input  logic [pfgw_pkg::X_W-1:0]    pos_x,
  input  logic [pfgw_pkg::Y_W-1:0]    pos_y,
  input  logic                        pixel_value,
  input  logic [pfgw_pkg::BITS_W-1:0] row_bits,
  input  logic [pfgw_pkg::FMT_W-1:0]  row_format,
  input  logic [pfgw_pkg::RW_W-1:0]   row_width,
  input  logic [pfgw_pkg::IDX_W-1:0]  read_index,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [pfgw_pkg::BYTE_W-1:0] read_byte,
  output logic                        was_dirty
);
  import pfgw_pkg::*;

  logic         q_ready;
  logic         q_valid;
  logic         push;
  op_t          front_op;
  op_t          q_op;
  back_status_t st;

  pfgw_front u_front (
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .command    (command),
    .pos_x      (pos_x),
    .pos_y      (pos_y),
    .pixel_value(pixel_value),
    .row_bits   (row_bits),
    .row_format (row_format),
    .row_width  (row_width),
    .read_index (read_index),
    .q_ready    (q_ready),
    .push       (push),
    .op         (front_op)
  );

  pfgw_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .push_op(front_op),
    .ready  (q_ready),
    .valid  (q_valid),
    .pop    (st.pop),
    .head   (q_op)
  );

  pfgw_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_op     (q_op),
    .status   (st),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .read_byte(read_byte),
    .was_dirty(was_dirty)
  );

  `PFGW_ASSERT_SAME(a_pop_needs_entry, st.pop, q_valid)
  `PFGW_ASSERT_SAME(a_busy_no_result, st.busy, !out_valid)
  `PFGW_ASSERT_NEXT(a_push_lands, push, q_valid)
  `PFGW_ASSERT_SAME(a_pop_free_slot, st.pop, !out_valid && !st.busy)

endmodule
